// ----- rtl/core/tie_pkg.sv -----
// ----------------------------------------------------------------------------
// tie_pkg: shared types and constants of the interpreter step unit
// statement and result payloads, mode, operator and error codes
// ----------------------------------------------------------------------------
package tie_pkg;

    // fixed widths of the statement and result fields
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 4;
    localparam int OP_W    = 4;
    localparam int LINE_W  = 16;
    localparam int LOAD_W  = 32;
    localparam int PRINT_W = 32;
    localparam int ERR_W   = 2;

    // default configuration of the unit
    localparam int DEF_NUM_VARS   = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_LINE_BITS  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_IF     = 3'd0,
        MODE_GOTO   = 3'd1,
        MODE_ASSIGN = 3'd2,
        MODE_PRINT  = 3'd3,
        MODE_STOP   = 3'd4,
        MODE_LOAD   = 3'd5
    } t_mode;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_EQ  = 4'd5,
        OP_NE  = 4'd6,
        OP_LT  = 4'd7,
        OP_GT  = 4'd8,
        OP_LE  = 4'd9,
        OP_GE  = 4'd10
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_BAD_OP   = 2'd2
    } t_err;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         target_index;
        logic [IDX_W-1:0]         left_index;
        logic [IDX_W-1:0]         right_index;
        logic [OP_W-1:0]          operator_code;
        logic [LINE_W-1:0]        jump_line;
        logic [LINE_W-1:0]        current_line;
        logic signed [LOAD_W-1:0] load_value;
    } t_stmt;

    typedef struct packed {
        logic [LINE_W-1:0]         next_line;
        logic                      halted;
        logic                      print_valid;
        logic signed [PRINT_W-1:0] print_value;
        logic [ERR_W-1:0]          error_code;
    } t_result;

endpackage

// ----- rtl/core/tie_ifs.sv -----
// ----------------------------------------------------------------------------
// tie_ifs: valid/ready channels of the interpreter step unit
// statement channel in, result channel out
// ----------------------------------------------------------------------------
interface tie_stmt_if;
    logic           valid;
    logic           ready;
    tie_pkg::t_stmt payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tie_res_if;
    logic             valid;
    logic             ready;
    tie_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tiny_interpreter_execute_step_unit.sv -----
// ----------------------------------------------------------------------------
// tiny_interpreter_execute_step_unit: one statement step of a small interpreter
// executes if/goto/assign/print/stop/load against a store of signed variables
// ----------------------------------------------------------------------------
// One statement is taken per transfer on i_stmt and exactly one result leaves on
// o_result. The unit works on one statement at a time: i_stmt.ready is high only
// while the sequencer is idle. All arithmetic and compares run through a single
// shared VALUE_BITS+1 bit add/subtract unit, so the time per statement is set by
// how often that unit is used: mul is shift-add, one multiplier bit per cycle;
// div and mod take the magnitudes in S_ABS_A and S_ABS_B, form one restoring
// quotient bit per cycle and fix the sign in S_FIX. The result sits in an
// output register, so a new statement is taken while the previous result still
// waits; the unit only stalls at the end of a statement if that register is
// still full. The variable store is a two-read, one-write memory with a
// reset-cleared valid bit per entry, so it reads as all zero after reset with
// no clearing pass. Divide or mod by zero, an operator that does not fit the
// mode, and an unused mode report an error code, raise halted and leave the
// store untouched.
module tiny_interpreter_execute_step_unit #(
    parameter int NUM_VARS   = tie_pkg::DEF_NUM_VARS,
    parameter int VALUE_BITS = tie_pkg::DEF_VALUE_BITS,
    parameter int LINE_BITS  = tie_pkg::DEF_LINE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tie_stmt_if.sink     i_stmt,
    tie_res_if.source    o_result
);

    localparam int VW    = VALUE_BITS;
    localparam int AW    = $clog2(NUM_VARS);
    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_MUL,
        S_FIX,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    // statement fields held for the whole step
    logic [tie_pkg::MODE_W-1:0] r_mode;
    logic [tie_pkg::OP_W-1:0]   r_op;
    logic [AW-1:0]              r_t;
    logic [LINE_BITS-1:0]       r_jump;
    logic [LINE_BITS-1:0]       r_cur;
    logic [tie_pkg::LOAD_W-1:0] r_load;

    // variable store: two read ports at accept, one write port at finish
    logic [VW-1:0]       r_mem [NUM_VARS];
    logic [NUM_VARS-1:0] r_vld;
    logic [VW-1:0]       r_rd_a, r_rd_b;
    logic                r_va, r_vb;

    // iterative datapath
    logic [VW-1:0]    r_acc;   // product or partial remainder
    logic [VW-1:0]    r_quo;   // multiplier bits or dividend/quotient
    logic [VW-1:0]    r_dvs;   // multiplicand or divisor magnitude
    logic [CNT_W-1:0] r_cnt;

    // step result
    logic [VW-1:0]        r_res;
    logic [LINE_BITS-1:0] r_next;
    logic                 r_halt;
    logic                 r_pv;
    logic                 r_wr;
    tie_pkg::t_err        r_err;

    // step result as decoded
    logic [LINE_BITS-1:0] n_next;
    logic                 n_halt;
    logic                 n_pv;
    logic                 n_wr;
    tie_pkg::t_err        n_err;

    // output register
    logic             r_out_valid;
    tie_pkg::t_result r_out;

    logic          stmt_fire;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] addr_a, addr_b, addr_t;
    logic [VW-1:0] op_a, op_b;
    logic          a_neg, b_neg;
    logic [VW:0]   add_x, add_y, add_sum;
    logic          add_sub;
    logic          lt, eq, cond;
    logic          if_op_ok, asg_op_ok, is_divmod, last;
    logic [VW-1:0] fix_sel;
    logic          fix_neg;
    logic [LINE_BITS-1:0] cur_inc;

    // index taken modulo NUM_VARS; the 4-bit index needs at most seven subtracts
    function automatic logic [AW-1:0] f_pick(input logic [tie_pkg::IDX_W-1:0] idx);
        logic [8:0] v;
        v = 9'(idx);
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(NUM_VARS)) begin
                v = v - 9'(NUM_VARS);
            end
        end
        return v[AW-1:0];
    endfunction

    assign stmt_fire = i_stmt.valid && i_stmt.ready;
    assign i_stmt.ready = (r_state == S_IDLE);

    assign out_free = !r_out_valid || o_result.ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    assign addr_t = f_pick(i_stmt.payload.target_index);
    // print reads its target through the left port
    assign addr_a = (i_stmt.payload.mode == tie_pkg::MODE_PRINT) ? addr_t
                                                                 : f_pick(i_stmt.payload.left_index);
    assign addr_b = f_pick(i_stmt.payload.right_index);

    // entries never written read as zero
    assign op_a  = r_va ? r_rd_a : '0;
    assign op_b  = r_vb ? r_rd_b : '0;
    assign a_neg = op_a[VW-1];
    assign b_neg = op_b[VW-1];

    assign if_op_ok  = (r_op >= tie_pkg::OP_EQ) && (r_op <= tie_pkg::OP_GE);
    assign asg_op_ok = (r_op <= tie_pkg::OP_MOD);
    assign is_divmod = (r_op == tie_pkg::OP_DIV) || (r_op == tie_pkg::OP_MOD);
    assign last      = (r_cnt == '0);
    assign cur_inc   = r_cur + LINE_BITS'(1);

    assign wr_en = (r_state == S_FINISH) && out_free && r_wr;

    assign fix_sel = (r_op == tie_pkg::OP_DIV) ? r_quo : r_acc;
    assign fix_neg = (r_op == tie_pkg::OP_DIV) ? (a_neg ^ b_neg) : a_neg;

    // shared add/subtract unit, operands picked by sequencer state
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b1;
        case (r_state)
            S_DECODE: begin
                // signed compare for if, add or sub for assign
                add_x   = {op_a[VW-1], op_a};
                add_y   = {op_b[VW-1], op_b};
                add_sub = !((r_mode == tie_pkg::MODE_ASSIGN) && (r_op == tie_pkg::OP_ADD));
            end
            S_ABS_A: begin
                add_y = {1'b0, op_a};
            end
            S_ABS_B: begin
                add_y = {1'b0, op_b};
            end
            S_DIV: begin
                add_x = {r_acc, r_quo[VW-1]};
                add_y = {1'b0, r_dvs};
            end
            S_MUL: begin
                add_x   = {1'b0, r_acc};
                add_y   = {1'b0, r_dvs};
                add_sub = 1'b0;
            end
            S_FIX: begin
                add_y = {1'b0, fix_sel};
            end
            default: begin
                add_sub = 1'b1;
            end
        endcase
        add_sum = add_x + (add_sub ? ~add_y : add_y) + {{VW{1'b0}}, add_sub};
    end

    assign lt = add_sum[VW];
    assign eq = (add_sum == '0);

    always_comb begin
        case (r_op)
            tie_pkg::OP_EQ: cond = eq;
            tie_pkg::OP_NE: cond = !eq;
            tie_pkg::OP_LT: cond = lt;
            tie_pkg::OP_GT: cond = !lt && !eq;
            tie_pkg::OP_LE: cond = lt || eq;
            default:        cond = !lt;
        endcase
    end

    // next line, halt, print, write and error of the statement, settled in decode
    always_comb begin
        n_next = cur_inc;
        n_halt = 1'b0;
        n_pv   = 1'b0;
        n_wr   = 1'b0;
        n_err  = tie_pkg::ERR_NONE;
        case (r_mode)
            tie_pkg::MODE_IF: begin
                if (!if_op_ok) begin
                    n_err = tie_pkg::ERR_BAD_OP;
                end else if (cond) begin
                    n_next = r_jump;
                end
            end
            tie_pkg::MODE_GOTO: begin
                n_next = r_jump;
            end
            tie_pkg::MODE_ASSIGN: begin
                if (!asg_op_ok) begin
                    n_err = tie_pkg::ERR_BAD_OP;
                end else if (is_divmod && (op_b == '0)) begin
                    n_err = tie_pkg::ERR_DIV_ZERO;
                end else begin
                    n_wr = 1'b1;
                end
            end
            tie_pkg::MODE_PRINT: begin
                n_pv = 1'b1;
            end
            tie_pkg::MODE_STOP: begin
                n_halt = 1'b1;
                n_next = r_cur;
            end
            tie_pkg::MODE_LOAD: begin
                n_wr = 1'b1;
            end
            default: begin
                n_err = tie_pkg::ERR_BAD_OP;
            end
        endcase
        // any error halts on the current line
        if (n_err != tie_pkg::ERR_NONE) begin
            n_halt = 1'b1;
            n_next = r_cur;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (stmt_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if ((r_mode == tie_pkg::MODE_ASSIGN) && asg_op_ok) begin
                    if (r_op == tie_pkg::OP_MUL) begin
                        n_state = S_MUL;
                    end else if (is_divmod && (op_b != '0)) begin
                        n_state = S_ABS_A;
                    end
                end
            end
            S_ABS_A: n_state = S_ABS_B;
            S_ABS_B: n_state = S_DIV;
            S_DIV: begin
                if (last) begin
                    n_state = S_FIX;
                end
            end
            S_MUL: begin
                if (last) begin
                    n_state = S_FINISH;
                end
            end
            S_FIX: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a new result at finish, else drop the one taken by the sink
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (stmt_fire) begin
                        r_mode <= i_stmt.payload.mode;
                        r_op   <= i_stmt.payload.operator_code;
                        r_t    <= addr_t;
                        r_jump <= LINE_BITS'(i_stmt.payload.jump_line);
                        r_cur  <= LINE_BITS'(i_stmt.payload.current_line);
                        r_load <= i_stmt.payload.load_value;
                    end
                end
                S_DECODE: begin
                    r_next <= n_next;
                    r_halt <= n_halt;
                    r_pv   <= n_pv;
                    r_wr   <= n_wr;
                    r_err  <= n_err;
                    if (r_mode == tie_pkg::MODE_LOAD) begin
                        r_res <= VW'($signed(r_load));
                    end else begin
                        r_res <= add_sum[VW-1:0];
                    end
                    // shift-add multiply: a is shifted up, b scanned from lsb
                    r_acc <= '0;
                    r_dvs <= op_a;
                    r_quo <= op_b;
                    r_cnt <= CNT_W'(VALUE_BITS - 1);
                end
                S_ABS_A: begin
                    r_quo <= a_neg ? add_sum[VW-1:0] : op_a;
                end
                S_ABS_B: begin
                    r_dvs <= b_neg ? add_sum[VW-1:0] : op_b;
                    r_acc <= '0;
                    r_cnt <= CNT_W'(VALUE_BITS - 1);
                end
                S_DIV: begin
                    // restoring step: keep the difference when it did not go negative
                    if (!add_sum[VW]) begin
                        r_acc <= add_sum[VW-1:0];
                        r_quo <= {r_quo[VW-2:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[VW-2:0], r_quo[VW-1]};
                        r_quo <= {r_quo[VW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                S_MUL: begin
                    if (r_quo[0]) begin
                        r_acc <= add_sum[VW-1:0];
                    end
                    r_dvs <= {r_dvs[VW-2:0], 1'b0};
                    r_quo <= {1'b0, r_quo[VW-1:1]};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (last) begin
                        r_res <= r_quo[0] ? add_sum[VW-1:0] : r_acc;
                    end
                end
                S_FIX: begin
                    r_res <= fix_neg ? add_sum[VW-1:0] : fix_sel;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out.next_line       <= 16'(r_next);
                        r_out.halted          <= r_halt;
                        r_out.print_valid     <= r_pv;
                        r_out.print_value     <= r_pv ? 32'($signed(op_a)) : '0;
                        r_out.error_code      <= r_err;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // store valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_t] <= 1'b1;
        end
    end

    // store array: write at finish, both reads registered at accept
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_t] <= r_res;
        end
        if (stmt_fire) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
            r_va   <= r_vld[addr_a];
            r_vb   <= r_vld[addr_b];
        end
    end

endmodule

// ----- rtl/core/tie_checker.sv -----
// ----------------------------------------------------------------------------
// tie_checker: port-level checks of the interpreter step unit
// bound to the top level, watches both channels over time
// ----------------------------------------------------------------------------
module tie_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input tie_pkg::t_result            i_out_payload
);

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed or dropped while stalled");

    // one statement at a time: no second transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("statement taken while previous one still executing");

    // any error halts
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload.error_code != tie_pkg::ERR_NONE)
            |-> i_out_payload.halted)
        else $error("error reported without halt");

    // print never halts and never errors
    a_print_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.print_valid
            |-> !i_out_payload.halted && (i_out_payload.error_code == tie_pkg::ERR_NONE))
        else $error("print result with halt or error");

    // no print value outside print
    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.print_valid |-> (i_out_payload.print_value == '0))
        else $error("print value set outside print");

endmodule

bind tiny_interpreter_execute_step_unit tie_checker u_tie_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_stmt.valid),
    .i_in_ready    (i_stmt.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interpreter step unit
// a short table of hand-picked statements, then about eleven hundred random
// ones; every result transfer is checked field by field against the expected
// result in the table or a shadow interpreter with its own copy of the store
// ----------------------------------------------------------------------------
module tb_top;
    import tie_pkg::*;

    localparam int VW = DEF_VALUE_BITS;
    typedef logic [VW-1:0] t_word;

    // spare codes that the unit must reject
    localparam logic [MODE_W-1:0] MODE_SPARE_A  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B  = 3'd7;
    localparam logic [OP_W-1:0]   OP_UNUSED_LO  = 4'd11;
    localparam logic [OP_W-1:0]   OP_UNUSED_HI  = 4'd15;

    localparam int RANDOM_ITEMS  = 1125;
    localparam int TAIL_ITEMS    = 150;
    localparam int PAUSE_AT      = 600;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct {
        t_stmt   stmt;
        bit      known;
        t_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tie_stmt_if stmt_ch ();
    tie_res_if  res_ch ();

    tiny_interpreter_execute_step_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stmt   (stmt_ch),
        .o_result (res_ch)
    );

    // shadow copy of the variable store, cleared like the unit after reset
    t_word   shadow_vars [DEF_NUM_VARS];
    t_result pending_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      idle_level     = 1;
    bit      hold_active    = 1'b0;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : reset_gen
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // shadow interpreter: one statement in, the result it must give out
    // ------------------------------------------------------------------
    function automatic t_result execute_statement(input t_stmt s);
        t_result r;
        t_word   a;
        t_word   b;
        t_word   ma;
        t_word   mb;
        t_word   res;
        bit      taken;
        r = '0;
        a = shadow_vars[s.left_index];
        b = shadow_vars[s.right_index];
        r.next_line  = s.current_line + 16'd1;
        r.error_code = ERR_NONE;
        case (s.mode)
            MODE_IF: begin
                if (s.operator_code < OP_EQ || s.operator_code > OP_GE) begin
                    r.error_code = ERR_BAD_OP;
                end else begin
                    case (s.operator_code)
                        OP_EQ:   taken = (a == b);
                        OP_NE:   taken = (a != b);
                        OP_LT:   taken = ($signed(a) <  $signed(b));
                        OP_GT:   taken = ($signed(a) >  $signed(b));
                        OP_LE:   taken = ($signed(a) <= $signed(b));
                        default: taken = ($signed(a) >= $signed(b));
                    endcase
                    if (taken) r.next_line = s.jump_line;
                end
            end
            MODE_GOTO: begin
                r.next_line = s.jump_line;
            end
            MODE_ASSIGN: begin
                if (s.operator_code > OP_MOD) begin
                    r.error_code = ERR_BAD_OP;
                end else if ((s.operator_code == OP_DIV || s.operator_code == OP_MOD)
                             && b == '0) begin
                    r.error_code = ERR_DIV_ZERO;
                end else begin
                    // divide on magnitudes, truncating toward zero
                    ma = a[VW-1] ? (~a) + 1'b1 : a;
                    mb = b[VW-1] ? (~b) + 1'b1 : b;
                    case (s.operator_code)
                        OP_ADD: res = a + b;
                        OP_SUB: res = a - b;
                        OP_MUL: res = a * b;
                        OP_DIV: begin
                            res = ma / mb;
                            if (a[VW-1] != b[VW-1]) res = (~res) + 1'b1;
                        end
                        default: begin
                            // remainder follows the dividend's sign
                            res = ma % mb;
                            if (a[VW-1]) res = (~res) + 1'b1;
                        end
                    endcase
                    shadow_vars[s.target_index] = res;
                end
            end
            MODE_PRINT: begin
                r.print_valid = 1'b1;
                r.print_value = shadow_vars[s.target_index];
            end
            MODE_STOP: begin
                r.halted    = 1'b1;
                r.next_line = s.current_line;
            end
            MODE_LOAD: begin
                shadow_vars[s.target_index] = s.load_value;
            end
            default: begin
                r.error_code = ERR_BAD_OP;
            end
        endcase
        if (r.error_code != ERR_NONE) begin
            r.halted    = 1'b1;
            r.next_line = s.current_line;
        end
        return r;
    endfunction

    function automatic t_stmt mk_stmt(input logic [MODE_W-1:0] mode,
                                      input logic [IDX_W-1:0] tgt,
                                      input logic [IDX_W-1:0] lft,
                                      input logic [IDX_W-1:0] rgt,
                                      input logic [OP_W-1:0] op,
                                      input logic [LINE_W-1:0] jump,
                                      input logic [LINE_W-1:0] cur,
                                      input logic [LOAD_W-1:0] load);
        t_stmt s;
        s.mode          = mode;
        s.target_index  = tgt;
        s.left_index    = lft;
        s.right_index   = rgt;
        s.operator_code = op;
        s.jump_line     = jump;
        s.current_line  = cur;
        s.load_value    = load;
        return s;
    endfunction

    function automatic t_result mk_res(input logic [LINE_W-1:0] next, input logic halted,
                                       input logic pvalid, input logic [PRINT_W-1:0] pval,
                                       input t_err err);
        t_result r;
        r.next_line   = next;
        r.halted      = halted;
        r.print_valid = pvalid;
        r.print_value = pval;
        r.error_code  = err;
        return r;
    endfunction

    function automatic t_dir_row row_pred(input t_stmt s);
        t_dir_row d;
        d.stmt  = s;
        d.known = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic t_dir_row row_known(input t_stmt s, input t_result w);
        t_dir_row d;
        d.stmt  = s;
        d.known = 1'b1;
        d.want  = w;
        return d;
    endfunction

    // operand values lean on the extremes and on small numbers near zero
    function automatic t_word pick_value();
        t_word v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'hffff_ffff;
                    3:       v = '0;
                    default: v = 32'd1;
                endcase
            end
            1:       v = t_word'($urandom_range(0, 40)) - 32'd20;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_stmt random_stmt();
        t_stmt       s;
        int unsigned pick;
        s.target_index  = IDX_W'($urandom_range(0, 15));
        s.left_index    = IDX_W'($urandom_range(0, 15));
        s.right_index   = IDX_W'($urandom_range(0, 15));
        s.operator_code = OP_W'($urandom_range(0, 15));
        s.jump_line     = LINE_W'($urandom);
        s.current_line  = ($urandom_range(0, 15) == 0) ? 16'hffff : 16'($urandom);
        s.load_value    = pick_value();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            s.mode = MODE_LOAD;
        end else if (pick < 55) begin
            s.mode          = MODE_ASSIGN;
            s.operator_code = OP_W'($urandom_range(OP_ADD, OP_MOD));
        end else if (pick < 75) begin
            s.mode          = MODE_IF;
            s.operator_code = OP_W'($urandom_range(OP_EQ, OP_GE));
        end else if (pick < 85) begin
            s.mode = MODE_PRINT;
        end else if (pick < 90) begin
            s.mode = MODE_GOTO;
        end else if (pick < 93) begin
            s.mode = MODE_STOP;
        end else if (pick < 95) begin
            // noise: the two unused modes
            s.mode = MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_B));
        end else if (pick < 97) begin
            // noise: compare or unused code in an assign
            s.mode          = MODE_ASSIGN;
            s.operator_code = OP_W'($urandom_range(OP_EQ, OP_UNUSED_HI));
        end else begin
            // noise: arithmetic or unused code in an if
            s.mode = MODE_IF;
            if ($urandom_range(0, 1) == 0)
                s.operator_code = OP_W'($urandom_range(OP_ADD, OP_MOD));
            else
                s.operator_code = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d came with nothing pending: %p",
                                      results_seen, got));
        end else begin
            want = pending_results.pop_front();
            if (got.next_line !== want.next_line)
                report_mismatch($sformatf("result %0d next_line got %h want %h",
                                          results_seen, got.next_line, want.next_line));
            if (got.halted !== want.halted)
                report_mismatch($sformatf("result %0d halted got %b want %b",
                                          results_seen, got.halted, want.halted));
            if (got.print_valid !== want.print_valid)
                report_mismatch($sformatf("result %0d print_valid got %b want %b",
                                          results_seen, got.print_valid, want.print_valid));
            if (got.print_value !== want.print_value)
                report_mismatch($sformatf("result %0d print_value got %h want %h",
                                          results_seen, got.print_value, want.print_value));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("result %0d error_code got %h want %h",
                                          results_seen, got.error_code, want.error_code));
        end
        results_seen++;
    endtask

    // offer one statement and hold it until the transfer; valid stays high
    task automatic send_stmt(input t_stmt s, input bit known, input t_result known_res);
        t_result pred;
        stmt_ch.valid   <= 1'b1;
        stmt_ch.payload <= s;
        do @(posedge i_clk); while (stmt_ch.ready !== 1'b1);
        pred = execute_statement(s);
        pending_results.push_back(known ? known_res : pred);
    endtask

    // random gap on the statement side, skipped while the result side is held
    task automatic maybe_idle();
        int gap;
        if (hold_active || idle_level == 0) return;
        if ($urandom_range(0, (idle_level == 1) ? 7 : 2) != 0) return;
        gap = $urandom_range(1, 18);
        stmt_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // statement side: directed table, then random statements
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row dir_rows [$];
        t_result  none_res;
        stmt_ch.valid   <= 1'b0;
        stmt_ch.payload <= '0;
        none_res = '0;

        // v1 = max, v2 = min, v3 = -1, v4 and v7 never written
        dir_rows.push_back(row_known(mk_stmt(MODE_PRINT, 4'd0, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'd10, 32'd0), mk_res(16'd11, 1'b0, 1'b1, 32'd0, ERR_NONE)));
        dir_rows.push_back(row_known(mk_stmt(MODE_LOAD, 4'd1, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'd11, 32'h7fff_ffff), mk_res(16'd12, 1'b0, 1'b0, 32'd0, ERR_NONE)));
        dir_rows.push_back(row_known(mk_stmt(MODE_LOAD, 4'd2, 4'd15, 4'd15, OP_UNUSED_HI,
                16'hffff, 16'd12, 32'h8000_0000), mk_res(16'd13, 1'b0, 1'b0, 32'd0, ERR_NONE)));
        // line plus one wraps to zero
        dir_rows.push_back(row_known(mk_stmt(MODE_LOAD, 4'd3, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'hffff, 32'hffff_ffff), mk_res(16'd0, 1'b0, 1'b0, 32'd0, ERR_NONE)));
        // most negative over minus one wraps, remainder zero
        dir_rows.push_back(row_pred(mk_stmt(MODE_ASSIGN, 4'd5, 4'd2, 4'd3, OP_DIV,
                16'd0, 16'd20, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_PRINT, 4'd5, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'd21, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_ASSIGN, 4'd6, 4'd2, 4'd3, OP_MOD,
                16'd0, 16'd22, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_PRINT, 4'd6, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'd23, 32'd0)));
        // divide and mod by zero
        dir_rows.push_back(row_known(mk_stmt(MODE_ASSIGN, 4'd7, 4'd1, 4'd4, OP_DIV,
                16'd0, 16'd100, 32'd0), mk_res(16'd100, 1'b1, 1'b0, 32'd0, ERR_DIV_ZERO)));
        dir_rows.push_back(row_known(mk_stmt(MODE_ASSIGN, 4'd7, 4'd2, 4'd4, OP_MOD,
                16'd0, 16'd101, 32'd0), mk_res(16'd101, 1'b1, 1'b0, 32'd0, ERR_DIV_ZERO)));
        // operators that do not fit the mode
        dir_rows.push_back(row_known(mk_stmt(MODE_ASSIGN, 4'd7, 4'd1, 4'd2, OP_EQ,
                16'd0, 16'd102, 32'd0), mk_res(16'd102, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        dir_rows.push_back(row_known(mk_stmt(MODE_ASSIGN, 4'd7, 4'd1, 4'd2, OP_UNUSED_HI,
                16'd0, 16'd103, 32'd0), mk_res(16'd103, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        dir_rows.push_back(row_known(mk_stmt(MODE_IF, 4'd0, 4'd1, 4'd1, OP_ADD,
                16'd500, 16'd104, 32'd0), mk_res(16'd104, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        dir_rows.push_back(row_known(mk_stmt(MODE_IF, 4'd0, 4'd1, 4'd1, OP_UNUSED_LO,
                16'd500, 16'd105, 32'd0), mk_res(16'd105, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        // unused modes
        dir_rows.push_back(row_known(mk_stmt(MODE_SPARE_A, 4'd7, 4'd1, 4'd2, OP_ADD,
                16'd0, 16'd106, 32'd5), mk_res(16'd106, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        dir_rows.push_back(row_known(mk_stmt(MODE_SPARE_B, 4'd7, 4'd1, 4'd2, OP_ADD,
                16'd0, 16'd107, 32'd5), mk_res(16'd107, 1'b1, 1'b0, 32'd0, ERR_BAD_OP)));
        // v7 must still read zero after the errors
        dir_rows.push_back(row_known(mk_stmt(MODE_PRINT, 4'd7, 4'd0, 4'd0, OP_ADD,
                16'd0, 16'd108, 32'd0), mk_res(16'd109, 1'b0, 1'b1, 32'd0, ERR_NONE)));
        dir_rows.push_back(row_known(mk_stmt(MODE_STOP, 4'd0, 4'd0, 4'd0, OP_ADD,
                16'd7, 16'hffff, 32'd0), mk_res(16'hffff, 1'b1, 1'b0, 32'd0, ERR_NONE)));
        dir_rows.push_back(row_known(mk_stmt(MODE_GOTO, 4'd0, 4'd0, 4'd0, OP_ADD,
                16'hffff, 16'd30, 32'd0), mk_res(16'hffff, 1'b0, 1'b0, 32'd0, ERR_NONE)));
        // every relation once
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd1, 4'd1, OP_EQ,
                16'd500, 16'd40, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd1, 4'd2, OP_NE,
                16'd501, 16'd41, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd2, 4'd1, OP_LT,
                16'd502, 16'd42, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd2, 4'd1, OP_GT,
                16'd503, 16'd43, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd3, 4'd3, OP_LE,
                16'd504, 16'd44, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_IF, 4'd0, 4'd4, 4'd3, OP_GE,
                16'd505, 16'd45, 32'd0)));
        // wrapping arithmetic at the extremes
        dir_rows.push_back(row_pred(mk_stmt(MODE_ASSIGN, 4'd8, 4'd1, 4'd1, OP_ADD,
                16'd0, 16'd50, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_ASSIGN, 4'd9, 4'd2, 4'd1, OP_SUB,
                16'd0, 16'd51, 32'd0)));
        dir_rows.push_back(row_pred(mk_stmt(MODE_ASSIGN, 4'd15, 4'd1, 4'd3, OP_MUL,
                16'd0, 16'd52, 32'd0)));

        @(posedge i_clk iff i_rst_n);

        foreach (dir_rows[i]) begin
            send_stmt(dir_rows[i].stmt, dir_rows[i].known, dir_rows[i].want);
            maybe_idle();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // idling changes every 64 statements; none at all in the tail
            if (n >= RANDOM_ITEMS - TAIL_ITEMS) idle_level = 0;
            else if (n % 64 == 0) idle_level = $urandom_range(0, 2);
            if (n == PAUSE_AT) begin
                // let the unit drain completely before going on
                stmt_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            send_stmt(random_stmt(), 1'b0, none_res);
            maybe_idle();
        end
        stmt_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: check each transfer, stall in bursts, one long hold
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result(res_ch.payload);
            if (!held && results_seen == HOLD_AT) begin
                // long hold: the output register fills and the input stalls
                held        = 1'b1;
                hold_active = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (idle_level != 0 &&
                    $urandom_range(0, (idle_level == 1) ? 15 : 3) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    // ends the run if no transfer happens on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((stmt_ch.valid === 1'b1 && stmt_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : store_clear
        foreach (shadow_vars[i]) shadow_vars[i] = '0;
    end

endmodule
